### rtl/edf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// edf_pkg: shared definitions of the escaped frame deframer
// Frame buffer sizing, register indexes, reset codes and the structures that
// pass between the byte parser and the frame store.
// ============================================================================
package edf_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int ADDR_W      = $clog2(FRAME_DEPTH);
	localparam int COUNT_W     = $clog2(FRAME_DEPTH + 1);
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd2;

	localparam logic [BYTE_W-1:0] RST_ESCAPE = 8'h10;
	localparam logic [BYTE_W-1:0] RST_START  = 8'h02;
	localparam logic [BYTE_W-1:0] RST_END    = 8'h03;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} edf_wr_t;

	typedef struct packed {
		logic               start;
		logic               empty;
		logic [COUNT_W-1:0] count;
	} edf_drain_t;

endpackage

### rtl/escaped_frame_deframer.sv
`timescale 1ns / 1ps
// ============================================================================
// escaped_frame_deframer: escape-stuffed byte stream deframer
// Removes escape stuffing from received bytes and emits each completed frame
// byte by byte, the final transfer marked by tlast.
// ============================================================================
// Received bytes are taken one per cycle while no frame is being emitted.
// When escape then end completes a frame holding N bytes, the input is held
// off while the frame buffer memory is read back through its single
// registered read port, each byte through a read state and then a wait
// state that lasts while the output is stalled; an empty frame skips the
// read state. An empty frame gives a single transfer with tuser low and
// tlast high. Frames longer than the buffer are dropped and the block
// returns to hunting for the next start sequence.
module escaped_frame_deframer
	import edf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [BYTE_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [BYTE_W-1:0]    m_axis_tdata,  // [7:0] frame_byte
	output logic                 m_axis_tuser,  // [0] byte_valid
	output logic                 m_axis_tlast
);

	edf_wr_t    wr;
	edf_drain_t drain;
	logic       busy;
	logic       accept;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	edf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.rx_byte   (s_axis_tdata),
		.wr        (wr),
		.drain     (drain)
	);

	edf_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr            (wr),
		.drain         (drain),
		.busy          (busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### rtl/edf_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// edf_parser: escape decoding and frame assembly
// Holds the code registers, the hunt and escape flags and the byte count,
// writes unstuffed bytes into the frame store and requests a drain when a
// frame completes.
// ============================================================================
module edf_parser
	import edf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 accept,
	input  logic [BYTE_W-1:0]    rx_byte,
	output edf_wr_t              wr,
	output edf_drain_t           drain
);

	logic [BYTE_W-1:0]  esc_code_q, stx_code_q, etx_code_q;
	logic               in_frame_q, esc_pend_q, start_pend_q;
	logic [COUNT_W-1:0] count_q;

	logic               in_frame_d, esc_pend_d, start_pend_d;
	logic [COUNT_W-1:0] count_d;
	logic               is_esc, is_stx, is_etx, full;

	assign is_esc = (rx_byte == esc_code_q);
	assign is_stx = (rx_byte == stx_code_q);
	assign is_etx = (rx_byte == etx_code_q);
	assign full   = (count_q == COUNT_W'(FRAME_DEPTH));

	always_comb begin
		in_frame_d    = in_frame_q;
		esc_pend_d    = esc_pend_q;
		start_pend_d  = start_pend_q;
		count_d       = count_q;
		wr.en         = 1'b0;
		wr.addr       = count_q[ADDR_W-1:0];
		wr.data       = rx_byte;
		drain.start   = 1'b0;
		drain.empty   = (count_q == '0);
		drain.count   = count_q;
		if (accept) begin
			if (in_frame_q) begin
				if (esc_pend_q) begin
					esc_pend_d = 1'b0;
					if (is_esc) begin
						if (full) begin
							count_d    = '0;
							in_frame_d = 1'b0;
						end else begin
							wr.en   = 1'b1;
							count_d = count_q + COUNT_W'(1);
						end
					end else if (is_etx) begin
						drain.start = 1'b1;
						count_d     = '0;
						in_frame_d  = 1'b0;
					end else if (is_stx) begin
						count_d = '0;
					end else begin
						count_d    = '0;
						in_frame_d = 1'b0;
					end
				end else if (is_esc) begin
					esc_pend_d = 1'b1;
				end else if (full) begin
					count_d    = '0;
					in_frame_d = 1'b0;
					esc_pend_d = 1'b0;
				end else begin
					wr.en   = 1'b1;
					count_d = count_q + COUNT_W'(1);
				end
			end else if (is_stx) begin
				start_pend_d = esc_pend_q;
			end else begin
				esc_pend_d = is_esc;
				if (start_pend_q) begin
					start_pend_d = 1'b0;
					in_frame_d   = 1'b1;
					wr.en        = 1'b1;
					wr.addr      = '0;
					count_d      = COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_code_q   <= RST_ESCAPE;
			stx_code_q   <= RST_START;
			etx_code_q   <= RST_END;
			in_frame_q   <= 1'b0;
			esc_pend_q   <= 1'b0;
			start_pend_q <= 1'b0;
			count_q      <= '0;
		end else begin
			in_frame_q   <= in_frame_d;
			esc_pend_q   <= esc_pend_d;
			start_pend_q <= start_pend_d;
			count_q      <= count_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ESCAPE: esc_code_q <= cfg_data;
					CFG_START:  stx_code_q <= cfg_data;
					CFG_END:    etx_code_q <= cfg_data;
					default:    ;
				endcase
			end
		end
	end

endmodule

### rtl/edf_store.sv
`timescale 1ns / 1ps
// ============================================================================
// edf_store: frame buffer memory, drain sequencer and output register
// A synchronous memory holds the unstuffed bytes; on a drain request the
// sequencer reads them back in order into the output register.
// ============================================================================
module edf_store
	import edf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  edf_wr_t           wr,
	input  edf_drain_t        drain,
	output logic              busy,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata,
	output logic              m_axis_tuser,
	output logic              m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [BYTE_W-1:0]  mem [FRAME_DEPTH];
	logic [BYTE_W-1:0]  rdata_q;
	logic [1:0]         state_q;
	logic [ADDR_W-1:0]  rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               empty_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_data_q;
	logic               out_user_q, out_last_q;
	logic               load, last;

	assign busy = (state_q != ST_IDLE);
	assign load = (state_q == ST_WAIT) && (!out_valid_q || m_axis_tready);
	assign last = empty_q || ((COUNT_W'(rd_ptr_q) + COUNT_W'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (drain.start) begin
						rd_ptr_q <= '0;
						count_q  <= drain.count;
						empty_q  <= drain.empty;
						state_q  <= drain.empty ? ST_WAIT : ST_READ;
					end
				end
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (load) begin
						rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
						state_q  <= last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= empty_q ? '0 : rdata_q;
			out_user_q <= !empty_q;
			out_last_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_IDLE))
		else $error("Frame store written during a drain.");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		drain.start |-> (state_q == ST_IDLE))
		else $error("Drain requested while a drain is running.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain.start |-> (drain.count <= COUNT_W'(FRAME_DEPTH)))
		else $error("Drain count exceeds the frame buffer.");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("Empty frame result not marked last.");

endmodule

### bench/escaped_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// escaped_frame_deframer_tb: self-checking bench for the escaped frame deframer
// Drives stuffed byte streams into the block, predicts the unstuffed frames
// from its own copy of the parser state, and checks every output transfer.
// It runs several code settings, including extreme and coinciding codes.
// ============================================================================
module escaped_frame_deframer_tb;
	import edf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 2 * FRAME_DEPTH + 16;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic              last;
	} frame_beat_t;

	typedef enum int {SHAPE_GOOD, SHAPE_ABORT, SHAPE_RESTART} frame_shape_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [BYTE_W-1:0]    m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	// Predicted parser state and register copies.
	logic [BYTE_W-1:0] held_bytes [FRAME_DEPTH];
	int                held_count;
	logic              in_frame;
	logic              escape_seen;
	logic              start_seen;
	logic [BYTE_W-1:0] escape_byte;
	logic [BYTE_W-1:0] start_byte;
	logic [BYTE_W-1:0] end_byte;

	frame_beat_t beats_due [$];

	int  mismatches   = 0;
	int  bytes_sent;
	int  beats_seen   = 0;
	int  frames_done;
	int  settings_run;
	int  stuck_cycles = 0;
	bit  sender_gaps;
	bit  receiver_stalls;

	escaped_frame_deframer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Appends one predicted output transfer to the end of the queue.
	task automatic add_due_beat(input logic [BYTE_W-1:0] data, input logic valid,
			input logic last);
		frame_beat_t beat;
		beat.data  = data;
		beat.valid = valid;
		beat.last  = last;
		beats_due.insert(beats_due.size(), beat);
	endtask

	task automatic hold_byte(input logic [BYTE_W-1:0] b);
		if (held_count >= FRAME_DEPTH) begin
			held_count  = 0;
			in_frame    = 1'b0;
			escape_seen = 1'b0;
		end else begin
			held_bytes[ADDR_W'(held_count)] = b;
			held_count++;
		end
	endtask

	// Advances the predicted parser by one received byte and queues the
	// transfers of any frame that it completes.
	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		if (in_frame) begin
			if (escape_seen) begin
				escape_seen = 1'b0;
				if (b == escape_byte) begin
					hold_byte(b);
				end else if (b == end_byte) begin
					if (held_count == 0) begin
						add_due_beat('0, 1'b0, 1'b1);
					end
					for (int k = 0; k < held_count; k++) begin
						add_due_beat(held_bytes[ADDR_W'(k)], 1'b1, (k + 1 == held_count));
					end
					frames_done++;
					held_count = 0;
					in_frame   = 1'b0;
				end else if (b == start_byte) begin
					held_count = 0;
				end else begin
					held_count = 0;
					in_frame   = 1'b0;
				end
			end else begin
				escape_seen = (b == escape_byte);
				if (!escape_seen) begin
					hold_byte(b);
				end
			end
		end else if (b == start_byte) begin
			start_seen = escape_seen;
		end else begin
			escape_seen = (b == escape_byte);
			if (start_seen) begin
				start_seen = 1'b0;
				in_frame   = 1'b1;
				held_count = 0;
				hold_byte(b);
			end
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		deframe_byte(b);
		bytes_sent++;
	endtask

	// Lets every predicted transfer arrive, then allows for a drain that
	// might still be running, so that the registers can be written safely.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ESCAPE: escape_byte = val;
			CFG_START:  start_byte  = val;
			CFG_END:    end_byte    = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_codes(input logic [BYTE_W-1:0] esc, input logic [BYTE_W-1:0] stx,
			input logic [BYTE_W-1:0] etx);
		settle();
		write_reg(CFG_ESCAPE, esc);
		write_reg(CFG_START, stx);
		write_reg(CFG_END, etx);
		settings_run++;
	endtask

	function automatic logic [BYTE_W-1:0] pick_payload();
		case ($urandom_range(0, 11))
			0:       return escape_byte;
			1:       return start_byte;
			2:       return end_byte;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)  return 0;
		if (r < 80) return $urandom_range(1, 8);
		return $urandom_range(9, 24);
	endfunction

	task automatic send_frame(input int len, input frame_shape_t shape);
		int                noise;
		logic [BYTE_W-1:0] b;
		noise = $urandom_range(0, 2);
		repeat (noise) send_byte(BYTE_W'($urandom_range(0, 255)));
		send_byte(escape_byte);
		send_byte(start_byte);
		for (int i = 0; i < len; i++) begin
			if (shape == SHAPE_RESTART && i == len / 2) begin
				send_byte(escape_byte);
				send_byte(start_byte);
			end
			b = pick_payload();
			if (b == escape_byte) begin
				send_byte(b);
			end
			send_byte(b);
		end
		send_byte(escape_byte);
		if (shape == SHAPE_ABORT) begin
			send_byte(BYTE_W'($urandom_range(0, 255)));
		end else begin
			send_byte(end_byte);
		end
	endtask

	task automatic run_random_frames(input int budget);
		int           first;
		frame_shape_t shape;
		int           r;
		first = bytes_sent;
		while (bytes_sent - first < budget) begin
			if ($urandom_range(0, 5) == 0) begin
				sender_gaps = ~sender_gaps;
			end
			if ($urandom_range(0, 5) == 0) begin
				receiver_stalls = ~receiver_stalls;
			end
			r = $urandom_range(0, 19);
			shape = (r < 14) ? SHAPE_GOOD : (r < 17) ? SHAPE_ABORT : SHAPE_RESTART;
			send_frame(pick_length(), shape);
		end
	endtask

	// Reset codes: plain frames, stuffed escapes, the empty frame, an escape
	// as the first stored byte, a restart, an abort and a doubled start.
	task automatic test_reset_codes();
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		send_byte(8'h00);
		send_byte(RST_START);
		send_byte(RST_ESCAPE);
		send_byte(RST_START);
		send_byte(8'hFF);
		send_byte(RST_ESCAPE);
		send_byte(RST_ESCAPE);
		send_byte(8'h00);
		send_byte(RST_ESCAPE);
		send_byte(RST_END);
		send_byte(RST_ESCAPE);
		send_byte(RST_START);
		send_byte(RST_ESCAPE);
		send_byte(RST_END);
		send_byte(RST_ESCAPE);
		send_byte(RST_START);
		send_byte(8'hAA);
		send_byte(RST_ESCAPE);
		send_byte(RST_START);
		send_byte(RST_ESCAPE);
		send_byte(RST_END);
		send_byte(RST_ESCAPE);
		send_byte(RST_START);
		send_byte(8'h55);
		send_byte(RST_ESCAPE);
		send_byte(8'h7F);
		send_byte(RST_ESCAPE);
		send_byte(RST_START);
		send_byte(RST_START);
		send_byte(8'h01);
		send_byte(RST_ESCAPE);
		send_byte(RST_END);
	endtask

	// A frame that exactly fills the buffer, then one that overflows it, then a short frame.
	task automatic test_buffer_limits();
		send_frame(FRAME_DEPTH, SHAPE_GOOD);
		send_frame(FRAME_DEPTH + 1, SHAPE_GOOD);
		send_frame(3, SHAPE_GOOD);
	endtask

	task automatic test_code_settings();
		apply_codes(8'hFF, 8'h00, 8'h80);
		write_reg(CFG_UNUSED, 8'hA5);
		run_random_frames(6);
		apply_codes(8'h00, 8'hFF, 8'h01);
		run_random_frames(6);
		// Escape equal to start: the hunt can never see an escaped start.
		apply_codes(8'h55, 8'h55, 8'hAA);
		run_random_frames(4);
		apply_codes(8'h7E, 8'h01, 8'h7E);
		run_random_frames(6);
		apply_codes(8'h10, 8'h20, 8'h20);
		run_random_frames(6);
		apply_codes(8'h33, 8'h33, 8'h33);
		run_random_frames(4);
		apply_codes(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
			BYTE_W'($urandom_range(0, 255)));
		run_random_frames(6);
		apply_codes(RST_ESCAPE, RST_START, RST_END);
		run_random_frames(6);
	endtask

	task automatic test_steady_flow();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		for (int n = 0; n < 3; n++) begin
			send_frame($urandom_range(0, 6), SHAPE_GOOD);
		end
	endtask

	initial begin
		int hold;
		hold = 0;
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_axis_tready = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 12) - 1;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (beats_due.size() == 0) begin
				report_mismatch("unexpected transfer, tdata", int'(m_axis_tdata), 0);
			end else begin
				want = beats_due.pop_front();
				if (m_axis_tdata != want.data)
					report_mismatch("frame_byte", int'(m_axis_tdata), int'(want.data));
				if (m_axis_tuser != want.valid)
					report_mismatch("byte_valid", int'(m_axis_tuser), int'(want.valid));
				if (m_axis_tlast != want.last)
					report_mismatch("frame_last", int'(m_axis_tlast), int'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= WATCHDOG_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
					$display("escaped_frame_deframer_tb: FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_ESCAPE;
		cfg_data        = '0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		bytes_sent      = 0;
		frames_done     = 0;
		settings_run    = 1;
		held_count      = 0;
		in_frame        = 1'b0;
		escape_seen     = 1'b0;
		start_seen      = 1'b0;
		escape_byte     = RST_ESCAPE;
		start_byte      = RST_START;
		end_byte        = RST_END;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_codes();
		test_buffer_limits();
		test_code_settings();
		test_steady_flow();
		settle();

		$display("sent %0d bytes under %0d code settings, %0d frames completed",
			bytes_sent, settings_run, frames_done);
		$display("checked %0d output transfers, %0d mismatches", beats_seen, mismatches);
		if (mismatches == 0) begin
			$display("escaped_frame_deframer_tb: PASS");
		end else begin
			$display("escaped_frame_deframer_tb: FAIL");
		end
		$finish;
	end

endmodule
